[rtl/core/hci_uart_rx_deframer_credits_unit_defines.svh]
// ----------------------------------------------------------------------------
// HCI H4 receive deframer: assertion macros
// Concurrent assertion wrappers used by the deframer modules.
// ----------------------------------------------------------------------------
`ifndef HCI_UART_RX_DEFRAMER_CREDITS_UNIT_DEFINES_SVH
`define HCI_UART_RX_DEFRAMER_CREDITS_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property checked outside reset
`define HRX_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hci rx deframer assertion failed");
// property checked on every edge, reset included
`define HRX_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("hci rx deframer assertion failed");
`else
`define HRX_ASSERT(lbl, clk, rst, prop)
`define HRX_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[rtl/core/hci_rx_pkg.sv]
// ----------------------------------------------------------------------------
// HCI H4 receive deframer package
// Phase and role codes, H4 constants and the word types shared by the stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hci_rx_pkg;

   // receive phase codes
   localparam logic [3:0] PH_TYPE   = 4'd0;
   localparam logic [3:0] PH_EVCODE = 4'd1;
   localparam logic [3:0] PH_EVLEN  = 4'd2;
   localparam logic [3:0] PH_EVPAR  = 4'd3;
   localparam logic [3:0] PH_HLO    = 4'd4;
   localparam logic [3:0] PH_HHI    = 4'd5;
   localparam logic [3:0] PH_LLO    = 4'd6;
   localparam logic [3:0] PH_LHI    = 4'd7;
   localparam logic [3:0] PH_DATA   = 4'd8;

   // role codes on the result word
   localparam logic [3:0] ROLE_TYPE    = 4'd0;
   localparam logic [3:0] ROLE_EVCODE  = 4'd1;
   localparam logic [3:0] ROLE_EVLEN   = 4'd2;
   localparam logic [3:0] ROLE_EVPARAM = 4'd3;
   localparam logic [3:0] ROLE_HLO     = 4'd4;
   localparam logic [3:0] ROLE_HHI     = 4'd5;
   localparam logic [3:0] ROLE_LLO     = 4'd6;
   localparam logic [3:0] ROLE_LHI     = 4'd7;
   localparam logic [3:0] ROLE_DATA    = 4'd8;
   localparam logic [3:0] ROLE_CREDIT  = 4'd9;

   // item kinds
   localparam logic KIND_RX  = 1'b0;
   localparam logic KIND_CMD = 1'b1;

   // H4 packet types and event codes
   localparam logic [7:0] TYPE_EVENT      = 8'h04;
   localparam logic [7:0] TYPE_ACL        = 8'h02;
   localparam logic [7:0] EV_CMD_COMPLETE = 8'h0E;
   localparam logic [7:0] EV_CMD_STATUS   = 8'h0F;

   localparam logic [7:0] CREDIT_RESET = 8'd1;

   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic [3:0]  role;
      logic [7:0]  data_byte;
      logic [15:0] payload_index;
      logic        last_of_packet;
      logic        type_error;
      logic [7:0]  credits;
      logic        credit_refused;
   } rsp_item_type;

endpackage

[rtl/core/hci_rx_in_stage.sv]
// ----------------------------------------------------------------------------
// HCI H4 receive deframer: input register
// Holds one accepted request word until the decode stage consumes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hci_rx_in_stage
   import hci_rx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   input  logic         consume,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         load;

   // take a new word when empty or when the held one leaves this cycle
   assign req_stall = valid_ff && !consume;
   assign load      = req_valid && !req_stall;
   assign valid_in  = load || (valid_ff && !consume);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[rtl/core/hci_rx_engine.sv]
// ----------------------------------------------------------------------------
// HCI H4 receive deframer: decode engine
// Phase machine, length and position counters and the command credit count.
// Builds the result word for the held item and updates state when it fires.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hci_uart_rx_deframer_credits_unit_defines.svh"

module hci_rx_engine
   import hci_rx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   output rsp_item_type result
);

   logic [3:0]  phase_ff,       phase_in;
   logic [7:0]  evt_code_ff,    evt_code_in;
   logic [15:0] remaining_ff,   remaining_in;
   logic [7:0]  length_low_ff,  length_low_in;
   logic [15:0] position_ff,    position_in;
   logic [7:0]  first_param_ff, first_param_in;
   logic [7:0]  second_param_ff, second_param_in;
   logic [7:0]  credit_ff,      credit_in;

   logic [15:0] remaining_dec;
   logic [15:0] position_inc;
   logic [15:0] acl_length;

   assign remaining_dec = remaining_ff - 16'd1;
   assign position_inc  = position_ff + 16'd1;
   assign acl_length    = {item.rx_byte, length_low_ff};

   // next state and result word
   always_comb begin
      phase_in        = phase_ff;
      evt_code_in     = evt_code_ff;
      remaining_in    = remaining_ff;
      length_low_in   = length_low_ff;
      position_in     = position_ff;
      first_param_in  = first_param_ff;
      second_param_in = second_param_ff;
      credit_in       = credit_ff;

      result                = '0;
      result.data_byte      = item.rx_byte;

      if (item.kind == KIND_CMD) begin
         // command sent: use a credit or refuse; receive phase untouched
         result.role      = ROLE_CREDIT;
         result.data_byte = 8'd0;
         if (credit_ff == 8'd0) begin
            result.credit_refused = 1'b1;
         end else begin
            credit_in = credit_ff - 8'd1;
         end
      end else begin
         case (phase_ff)
            PH_EVCODE: begin
               result.role = ROLE_EVCODE;
               evt_code_in = item.rx_byte;
               phase_in    = PH_EVLEN;
            end
            PH_EVLEN: begin
               result.role  = ROLE_EVLEN;
               remaining_in = {8'd0, item.rx_byte};
               position_in  = 16'd0;
               if (item.rx_byte == 8'd0) begin
                  result.last_of_packet = 1'b1;
                  phase_in              = PH_TYPE;
               end else begin
                  phase_in = PH_EVPAR;
               end
            end
            PH_EVPAR: begin
               result.role          = ROLE_EVPARAM;
               result.payload_index = position_ff;
               if (position_ff == 16'd0) begin
                  first_param_in = item.rx_byte;
               end
               if (position_ff == 16'd1) begin
                  second_param_in = item.rx_byte;
               end
               position_in  = position_inc;
               remaining_in = remaining_dec;
               // last parameter: reload credits from the completing event
               if (remaining_dec == 16'd0) begin
                  result.last_of_packet = 1'b1;
                  phase_in              = PH_TYPE;
                  if (evt_code_ff == EV_CMD_COMPLETE && position_inc >= 16'd1) begin
                     credit_in = first_param_in;
                  end else if (evt_code_ff == EV_CMD_STATUS &&
                               position_inc >= 16'd2) begin
                     credit_in = second_param_in;
                  end
               end
            end
            PH_HLO: begin
               result.role = ROLE_HLO;
               phase_in    = PH_HHI;
            end
            PH_HHI: begin
               result.role = ROLE_HHI;
               phase_in    = PH_LLO;
            end
            PH_LLO: begin
               result.role   = ROLE_LLO;
               length_low_in = item.rx_byte;
               phase_in      = PH_LHI;
            end
            PH_LHI: begin
               result.role  = ROLE_LHI;
               remaining_in = acl_length;
               position_in  = 16'd0;
               if (acl_length == 16'd0) begin
                  result.last_of_packet = 1'b1;
                  phase_in              = PH_TYPE;
               end else begin
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               result.role          = ROLE_DATA;
               result.payload_index = position_ff;
               position_in          = position_inc;
               remaining_in         = remaining_dec;
               if (remaining_dec == 16'd0) begin
                  result.last_of_packet = 1'b1;
                  phase_in              = PH_TYPE;
               end
            end
            default: begin
               // packet type byte; anything unknown is flagged and skipped
               result.role = ROLE_TYPE;
               if (item.rx_byte == TYPE_EVENT) begin
                  phase_in = PH_EVCODE;
               end else if (item.rx_byte == TYPE_ACL) begin
                  phase_in = PH_HLO;
               end else begin
                  result.type_error = 1'b1;
                  phase_in          = PH_TYPE;
               end
            end
         endcase
      end

      result.credits = credit_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_TYPE;
         evt_code_ff     <= 8'd0;
         remaining_ff    <= 16'd0;
         length_low_ff   <= 8'd0;
         position_ff     <= 16'd0;
         first_param_ff  <= 8'd0;
         second_param_ff <= 8'd0;
         credit_ff       <= CREDIT_RESET;
      end else if (fire) begin
         phase_ff        <= phase_in;
         evt_code_ff     <= evt_code_in;
         remaining_ff    <= remaining_in;
         length_low_ff   <= length_low_in;
         position_ff     <= position_in;
         first_param_ff  <= first_param_in;
         second_param_ff <= second_param_in;
         credit_ff       <= credit_in;
      end
   end

   // command words never move the receive phase
   `HRX_ASSERT(a_cmd_keeps_phase, clock, reset,
      fire && item.kind == KIND_CMD |=> $stable(phase_ff))
   // a refusal only happens with the count at zero, and leaves it there
   `HRX_ASSERT(a_refuse_at_zero, clock, reset,
      fire && result.credit_refused |-> credit_ff == 8'd0 && result.credits == 8'd0)
   // end of packet or bad type byte returns to waiting for a type byte
   `HRX_ASSERT(a_last_to_type, clock, reset,
      fire && (result.last_of_packet || result.type_error) |=> phase_ff == PH_TYPE)
   // the payload index is zero on every word outside a packet body
   `HRX_ASSERT(a_index_in_body, clock, reset,
      fire && result.payload_index != 16'd0 |->
         result.role == ROLE_EVPARAM || result.role == ROLE_DATA)

endmodule

[rtl/core/hci_rx_out_stage.sv]
// ----------------------------------------------------------------------------
// HCI H4 receive deframer: result register
// Holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hci_rx_out_stage
   import hci_rx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type result,
   output logic         ready,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   // free when empty or when the held word is taken this cycle
   assign ready    = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

[rtl/core/hci_uart_rx_deframer_credits_unit.sv]
// An accepted word passes through the input register and then the result register.
// Throughput: one word per cycle while the result side does not stall, set by the single-pass decode stage.
// While a finished result waits under stall, the input register takes one
// more word and then the input stalls until the result is taken.
// Reset (synchronous) empties both registers, returns to waiting for a type
// byte and loads the command credit count with 1.
// ----------------------------------------------------------------------------
// HCI H4 receive deframer with command credits: top level
// Classifies received H4 bytes, marks packet ends and tracks command credits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hci_uart_rx_deframer_credits_unit
   import hci_rx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_role,
   output logic [7:0]  rsp_data_byte,
   output logic [15:0] rsp_payload_index,
   output logic        rsp_last_of_packet,
   output logic        rsp_type_error,
   output logic [7:0]  rsp_credits,
   output logic        rsp_credit_refused
);

   req_item_type req_item;
   req_item_type held_item;
   logic         held_valid;
   logic         out_ready;
   logic         fire;
   rsp_item_type result;
   rsp_item_type rsp_item;

   assign req_item.kind    = req_kind;
   assign req_item.rx_byte = req_rx_byte;

   // held word moves on when the result register can take it
   assign fire = held_valid && out_ready;

   hci_rx_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .consume    (fire),
      .item_valid (held_valid),
      .item       (held_item)
   );

   hci_rx_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (held_item),
      .result (result)
   );

   hci_rx_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .result    (result),
      .ready     (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   assign rsp_role           = rsp_item.role;
   assign rsp_data_byte      = rsp_item.data_byte;
   assign rsp_payload_index  = rsp_item.payload_index;
   assign rsp_last_of_packet = rsp_item.last_of_packet;
   assign rsp_type_error     = rsp_item.type_error;
   assign rsp_credits        = rsp_item.credits;
   assign rsp_credit_refused = rsp_item.credit_refused;

endmodule

[tb/hci_rx_scoreboard_pkg.sv]
// ----------------------------------------------------------------------------
// HCI H4 receive deframer: scoreboard
// Predicts the result word of every accepted input word (phase machine,
// payload position and command credits) and checks results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hci_rx_tb_pkg;

   import hci_rx_pkg::*;

   class hci_rx_scoreboard;

      // predicted receive state
      logic [3:0]   rx_phase;
      logic [7:0]   evt_code;
      logic [15:0]  bytes_left;
      logic [7:0]   acl_len_low;
      logic [15:0]  payload_pos;
      logic [7:0]  param0;
      logic [7:0]  param1;
      logic [7:0]  credit_count;

      rsp_item_type expected_q[$];
      int unsigned  error_count;
      int unsigned  words_checked;

      localparam int unsigned REPORT_LINES_MAX = 40;

      function new();
         rx_phase      = PH_TYPE;
         evt_code      = '0;
         bytes_left    = '0;
         acl_len_low   = '0;
         payload_pos   = '0;
         param0        = '0;
         param1        = '0;
         credit_count  = CREDIT_RESET;
         error_count   = 0;
         words_checked = 0;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // work out the result word of one accepted input word
      function void note_input(logic kind, logic [7:0] rx_byte);
         rsp_item_type want;
         want = '0;
         if (kind == KIND_CMD) begin
            want.role = ROLE_CREDIT;
            if (credit_count == 8'd0) want.credit_refused = 1'b1;
            else credit_count = credit_count - 8'd1;
         end else begin
            want.data_byte = rx_byte;
            case (rx_phase)
               PH_EVCODE: begin
                  want.role = ROLE_EVCODE;
                  evt_code  = rx_byte;
                  rx_phase  = PH_EVLEN;
               end
               PH_EVLEN: begin
                  want.role   = ROLE_EVLEN;
                  bytes_left  = {8'd0, rx_byte};
                  payload_pos = '0;
                  if (rx_byte == 8'd0) begin
                     want.last_of_packet = 1'b1;
                     rx_phase = PH_TYPE;
                  end else begin
                     rx_phase = PH_EVPAR;
                  end
               end
               PH_EVPAR: begin
                  want.role          = ROLE_EVPARAM;
                  want.payload_index = payload_pos;
                  if (payload_pos == 16'd0) param0 = rx_byte;
                  if (payload_pos == 16'd1) param1 = rx_byte;
                  payload_pos = payload_pos + 16'd1;
                  bytes_left  = bytes_left - 16'd1;
                  if (bytes_left == 16'd0) begin
                     want.last_of_packet = 1'b1;
                     rx_phase = PH_TYPE;
                     // credit reload at the last parameter
                     if (evt_code == EV_CMD_COMPLETE && payload_pos >= 16'd1)
                        credit_count = param0;
                     else if (evt_code == EV_CMD_STATUS && payload_pos >= 16'd2)
                        credit_count = param1;
                  end
               end
               PH_HLO: begin
                  want.role = ROLE_HLO;
                  rx_phase  = PH_HHI;
               end
               PH_HHI: begin
                  want.role = ROLE_HHI;
                  rx_phase  = PH_LLO;
               end
               PH_LLO: begin
                  want.role   = ROLE_LLO;
                  acl_len_low = rx_byte;
                  rx_phase    = PH_LHI;
               end
               PH_LHI: begin
                  want.role   = ROLE_LHI;
                  bytes_left  = {rx_byte, acl_len_low};
                  payload_pos = '0;
                  if (bytes_left == 16'd0) begin
                     want.last_of_packet = 1'b1;
                     rx_phase = PH_TYPE;
                  end else begin
                     rx_phase = PH_DATA;
                  end
               end
               PH_DATA: begin
                  want.role          = ROLE_DATA;
                  want.payload_index = payload_pos;
                  payload_pos = payload_pos + 16'd1;
                  bytes_left  = bytes_left - 16'd1;
                  if (bytes_left == 16'd0) begin
                     want.last_of_packet = 1'b1;
                     rx_phase = PH_TYPE;
                  end
               end
               default: begin
                  want.role = ROLE_TYPE;
                  if (rx_byte == TYPE_EVENT) rx_phase = PH_EVCODE;
                  else if (rx_byte == TYPE_ACL) rx_phase = PH_HLO;
                  else begin
                     want.type_error = 1'b1;
                     rx_phase = PH_TYPE;
                  end
               end
            endcase
         end
         want.credits = credit_count;
         expected_q.push_back(want);
      endfunction

      task report(string what, logic [15:0] want, logic [15:0] got);
         error_count++;
         if (error_count <= REPORT_LINES_MAX)
            $display("ERROR result word %0d: %s expected %h got %h",
                     words_checked, what, want, got);
      endtask

      // compare one accepted result word with the oldest prediction
      task check_result(rsp_item_type got);
         rsp_item_type want;
         words_checked++;
         if (expected_q.size() == 0) begin
            report("result word with none pending", 16'd0, 16'(got.role));
            return;
         end
         want = expected_q.pop_front();
         if (got.role !== want.role)
            report("role", 16'(want.role), 16'(got.role));
         if (got.data_byte !== want.data_byte)
            report("data_byte", 16'(want.data_byte), 16'(got.data_byte));
         if (got.payload_index !== want.payload_index)
            report("payload_index", want.payload_index, got.payload_index);
         if (got.last_of_packet !== want.last_of_packet)
            report("last_of_packet", 16'(want.last_of_packet), 16'(got.last_of_packet));
         if (got.type_error !== want.type_error)
            report("type_error", 16'(want.type_error), 16'(got.type_error));
         if (got.credits !== want.credits)
            report("credits", 16'(want.credits), 16'(got.credits));
         if (got.credit_refused !== want.credit_refused)
            report("credit_refused", 16'(want.credit_refused), 16'(got.credit_refused));
      endtask

   endclass

endpackage

[tb/hci_uart_rx_deframer_credits_unit_tb.sv]
// ----------------------------------------------------------------------------
// HCI H4 receive deframer with command credits: testbench
// Directed H4 packets and credit operations, then random packet streams with
// noise, under three sender/receiver stall mixes and one long receiver
// hold-off. Every result word is checked against the scoreboard prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hci_uart_rx_deframer_credits_unit_tb;

   import hci_rx_pkg::*;
   import hci_rx_tb_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned RANDOM_STOP    = 1820;
   localparam int unsigned MIX_ONE_END    = 620;
   localparam int unsigned MIX_TWO_END    = 1240;
   localparam int unsigned HOLD_CYCLES    = 60;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic        req_kind    = KIND_RX;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic [3:0]  rsp_role;
   logic [7:0]  rsp_data_byte;
   logic [15:0] rsp_payload_index;
   logic        rsp_last_of_packet;
   logic        rsp_type_error;
   logic [7:0]  rsp_credits;
   logic        rsp_credit_refused;

   hci_rx_scoreboard sb;

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned words_sent    = 0;
   int unsigned quiet_cycles  = 0;
   bit          hold_request  = 1'b0;

   logic [8:0]  opening_seq [0:25];

   hci_uart_rx_deframer_credits_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_role           (rsp_role),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_payload_index  (rsp_payload_index),
      .rsp_last_of_packet (rsp_last_of_packet),
      .rsp_type_error     (rsp_type_error),
      .rsp_credits        (rsp_credits),
      .rsp_credit_refused (rsp_credit_refused)
   );

   always #5 clock = ~clock;

   // offer one word, with random idle cycles ahead of it
   task automatic send_word(input logic kind, input logic [7:0] value);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_rx_byte <= value;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      sb.note_input(kind, value);
      words_sent++;
   endtask

   // received byte, sometimes preceded by a command-sent word
   task automatic send_rx_mixed(input logic [7:0] value);
      if ($urandom_range(99) < 12) send_word(KIND_CMD, 8'($urandom_range(255)));
      send_word(KIND_RX, value);
   endtask

   // event packet; mostly credit events, sometimes cut short
   task automatic send_random_event();
      int unsigned len;
      int unsigned cut;
      logic [7:0]  code;
      case ($urandom_range(2))
         0: code = EV_CMD_COMPLETE;
         1: code = EV_CMD_STATUS;
         default: code = 8'($urandom_range(255));
      endcase
      len = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(5);
      cut = ($urandom_range(19) == 0) ? $urandom_range(len) : len;
      send_rx_mixed(TYPE_EVENT);
      send_rx_mixed(code);
      send_rx_mixed(8'(len));
      for (int unsigned i = 0; i < cut; i++) begin
         // small parameters keep the credit count near zero
         if ($urandom_range(2) == 0) send_rx_mixed(8'($urandom_range(255)));
         else send_rx_mixed(8'($urandom_range(3)));
      end
   endtask

   task automatic send_random_acl();
      int unsigned len;
      len = ($urandom_range(24) == 0) ? $urandom_range(300) : $urandom_range(8);
      send_rx_mixed(TYPE_ACL);
      send_rx_mixed(8'($urandom_range(255)));
      send_rx_mixed(8'($urandom_range(255)));
      send_rx_mixed(8'(len));
      send_rx_mixed(8'(len >> 8));
      repeat (len) send_rx_mixed(8'($urandom_range(255)));
   endtask

   // receiver stall, with one long hold-off on request
   initial begin : rsp_side
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   // result word monitor
   always @(posedge clock) begin : rsp_monitor
      rsp_item_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got = {rsp_role, rsp_data_byte, rsp_payload_index, rsp_last_of_packet,
                rsp_type_error, rsp_credits, rsp_credit_refused};
         sb.check_result(got);
      end
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      bit hold_done;
      hold_done = 1'b0;
      sb = new();
      // unknown type, status event to zero credits, refused command,
      // complete event to 255, a used credit, zero-length event,
      // zero-length ACL, one-byte ACL
      opening_seq = '{
         {KIND_RX, 8'hFF},
         {KIND_RX, TYPE_EVENT}, {KIND_RX, EV_CMD_STATUS}, {KIND_RX, 8'h02},
         {KIND_RX, 8'h00}, {KIND_RX, 8'h00},
         {KIND_CMD, 8'h00},
         {KIND_RX, TYPE_EVENT}, {KIND_RX, EV_CMD_COMPLETE}, {KIND_RX, 8'h01},
         {KIND_RX, 8'hFF},
         {KIND_CMD, 8'hFF},
         {KIND_RX, TYPE_EVENT}, {KIND_RX, 8'h3E}, {KIND_RX, 8'h00},
         {KIND_RX, TYPE_ACL}, {KIND_RX, 8'h00}, {KIND_RX, 8'h00}, {KIND_RX, 8'h00},
         {KIND_RX, 8'h00},
         {KIND_RX, TYPE_ACL}, {KIND_RX, 8'hFF}, {KIND_RX, 8'hFF}, {KIND_RX, 8'h01},
         {KIND_RX, 8'h00}, {KIND_RX, 8'hA5}
      };
      send_idle_pct = 25;
      rsp_stall_pct = 81;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (opening_seq[i]) send_word(opening_seq[i][8], opening_seq[i][7:0]);

      // random packet stream
      while (words_sent < RANDOM_STOP) begin
         if (words_sent > MIX_TWO_END) begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
            if (!hold_done) begin
               hold_request = 1'b1;
               hold_done    = 1'b1;
            end
         end else if (words_sent > MIX_ONE_END) begin
            send_idle_pct = 81;
            rsp_stall_pct = 25;
         end
         case ($urandom_range(19))
            0, 1, 2, 3, 4, 5, 6, 7, 8: send_random_event();
            9, 10, 11, 12, 13, 14, 15, 16: send_random_acl();
            default: repeat ($urandom_range(1, 4)) send_rx_mixed(8'($urandom_range(255)));
         endcase
      end

      // long ACL packet left open: upper length bits in use
      send_rx_mixed(TYPE_ACL);
      send_rx_mixed(8'($urandom_range(255)));
      send_rx_mixed(8'($urandom_range(255)));
      send_rx_mixed(8'($urandom_range(255)));
      send_rx_mixed(8'($urandom_range(128, 255)));
      repeat (20) send_rx_mixed(8'($urandom_range(255)));

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
